[rtl/core/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg: shared constants and types for the Newton square root
// Fixed-point formats, widths and the handshake between sequencer and divider.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int INPUT_BITS  = 31;
	localparam int ITER_BITS   = 6;
	localparam int GUESS_BITS  = INPUT_BITS + FRAC_BITS;
	localparam int OUT_BITS    = GUESS_BITS;
	localparam int NUM_BITS    = INPUT_BITS + 2 * FRAC_BITS;
	localparam int CNT_BITS    = $clog2(NUM_BITS);

	localparam logic [ITER_BITS-1:0] ITER_RESET = ITER_BITS'(10);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/core/nsr_div.sv]
// ----------------------------------------------------------------------------
// nsr_div: shared restoring divider
// One quotient bit a cycle; quotient truncated to the guess width.
// ----------------------------------------------------------------------------
module nsr_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [nsr_pkg::NUM_BITS-1:0]      numer,
	input  logic [nsr_pkg::GUESS_BITS-1:0]    divisor,
	output logic [nsr_pkg::GUESS_BITS-1:0]    quotient,
	output nsr_pkg::div_stat_t                stat
);

	logic [nsr_pkg::NUM_BITS-1:0]   num_q;
	logic [nsr_pkg::GUESS_BITS-1:0] div_q;
	logic [nsr_pkg::GUESS_BITS-1:0] rem_q;
	logic [nsr_pkg::GUESS_BITS-1:0] quo_q;
	logic [nsr_pkg::CNT_BITS-1:0]   cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [nsr_pkg::GUESS_BITS:0]   rem_sh;
	logic [nsr_pkg::GUESS_BITS:0]   rem_sub;
	logic                           qbit;

	assign rem_sh  = {rem_q, num_q[nsr_pkg::NUM_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign qbit    = (rem_sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= nsr_pkg::CNT_BITS'(nsr_pkg::NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != '0);
				done_q <= (cnt_q == '0);
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[nsr_pkg::NUM_BITS-2:0], 1'b0};
			rem_q <= qbit ? rem_sub[nsr_pkg::GUESS_BITS-1:0] : rem_sh[nsr_pkg::GUESS_BITS-1:0];
			quo_q <= {quo_q[nsr_pkg::GUESS_BITS-2:0], qbit};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q)
		else $error("divider not busy after start");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finishing pass");

endmodule

[rtl/core/newton_square_root.sv]
// ----------------------------------------------------------------------------
// newton_square_root: Newton-Raphson square root, 16 fraction bits
// Sequencer around one shared bit-serial divider.
//
//   channel  direction  handshake                 payload
//   in       in         in_valid / in_stall       radicand (31 b)
//   out      out        out_valid / out_stall     root_estimate (47 b)
//   cfg      in         cfg_wr_en                 cfg_wr_data (iteration_count, 6 b)
//
// An item with radicand 0 or 1, or with iteration_count 0, skips the divider and
// goes to the output register. Otherwise each Newton step is one start state plus
// a divider pass over the 63 numerator bits, one numerator bit a cycle.
// One item is in work at a time; the next is taken once the result is loaded.
// A stalled result holds the sequencer in its final state; reset clears
// control state and sets iteration_count to 10.
// ----------------------------------------------------------------------------
module newton_square_root (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [nsr_pkg::INPUT_BITS-1:0]    radicand,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [nsr_pkg::OUT_BITS-1:0]      root_estimate,
	input  logic                              cfg_wr_en,
	input  logic [nsr_pkg::ITER_BITS-1:0]     cfg_wr_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [nsr_pkg::ITER_BITS-1:0]   iter_cfg_q;
	logic [nsr_pkg::ITER_BITS-1:0]   iter_left_q;
	logic [nsr_pkg::GUESS_BITS-1:0]  guess_q;
	logic [nsr_pkg::NUM_BITS-1:0]    num_q;
	logic                            out_valid_q;
	logic [nsr_pkg::OUT_BITS-1:0]    out_q;

	logic                            accept;
	logic                            small_in;
	logic                            div_start;
	logic [nsr_pkg::GUESS_BITS-1:0]  quotient;
	logic [nsr_pkg::GUESS_BITS:0]    sum;
	nsr_pkg::div_stat_t              div_stat;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign small_in  = (radicand[nsr_pkg::INPUT_BITS-1:1] == '0);
	assign div_start = (state_q == S_START);
	assign sum       = {1'b0, quotient} + {1'b0, guess_q};

	nsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (num_q),
		.divisor  (guess_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cfg_q <= nsr_pkg::ITER_RESET;
		end else if (cfg_wr_en) begin
			iter_cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			iter_left_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						iter_left_q <= iter_cfg_q;
						if (small_in || iter_cfg_q == '0) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						iter_left_q <= iter_left_q - 1'b1;
						state_q     <= (iter_left_q == nsr_pkg::ITER_BITS'(1)) ? S_FINISH : S_START;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q       <= guess_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_q <= {radicand, {(2 * nsr_pkg::FRAC_BITS){1'b0}}};
			if (small_in) begin
				guess_q <= {{(nsr_pkg::GUESS_BITS - nsr_pkg::FRAC_BITS - 1){1'b0}}, radicand[0],
					{nsr_pkg::FRAC_BITS{1'b0}}};
			end else begin
				guess_q <= {1'b0, radicand[nsr_pkg::INPUT_BITS-1:1], {nsr_pkg::FRAC_BITS{1'b0}}};
			end
		end else if (state_q == S_DIV && div_stat.done) begin
			guess_q <= sum[nsr_pkg::GUESS_BITS:1];
		end
	end

	assign out_valid     = out_valid_q;
	assign root_estimate = out_q;

	a_small_skip: assert property (@(posedge clk) disable iff (!arst_n)
		accept && small_in |=> state_q == S_FINISH)
		else $error("radicand below two entered the divider loop");

	a_start_runs_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |=> state_q == S_DIV && div_stat.busy)
		else $error("divider idle after a Newton step started");

	a_steps_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> iter_left_q != '0)
		else $error("Newton step running with no steps left");

	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE || state_q == S_FINISH |-> !div_stat.busy)
		else $error("divider busy outside a Newton step");

endmodule

[sim/newton_square_root_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_square_root_tb: self-checking bench for the Newton square root
// Drives radicands through the valid/stall input channel and compares every
// root estimate with a bit-exact fixed-point Newton predictor. A short
// directed table covers the extremes and the zero/one and zero-step cases,
// then random radicands run under several iteration counts and stall mixes.
// ----------------------------------------------------------------------------
module newton_square_root_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DIR_ROWS       = 22;

	typedef struct packed {
		logic [nsr_pkg::ITER_BITS-1:0]  steps;
		logic [nsr_pkg::INPUT_BITS-1:0] value;
		logic                           known;
		logic [nsr_pkg::OUT_BITS-1:0]   root;
	} dir_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [nsr_pkg::INPUT_BITS-1:0] radicand;
	logic                           out_valid;
	logic                           out_stall;
	logic [nsr_pkg::OUT_BITS-1:0]   root_estimate;
	logic                           cfg_wr_en;
	logic [nsr_pkg::ITER_BITS-1:0]  cfg_wr_data;

	logic [nsr_pkg::OUT_BITS-1:0]  expected_roots[$];
	logic [nsr_pkg::ITER_BITS-1:0] iter_setting;
	dir_row_t                      dir_rows [DIR_ROWS];
	int                            send_idle_pct;
	int                            recv_idle_pct;
	int                            items_sent;
	int                            roots_checked = 0;
	int                            mismatches    = 0;
	int                            quiet_cycles  = 0;

	newton_square_root dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.radicand      (radicand),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.root_estimate (root_estimate),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [nsr_pkg::OUT_BITS-1:0] newton_root(
		input logic [nsr_pkg::INPUT_BITS-1:0] n,
		input logic [nsr_pkg::ITER_BITS-1:0] steps);
		logic [127:0] scaled;
		logic [63:0]  guess;
		logic [63:0]  quot;
		if (n < 2) begin
			return nsr_pkg::OUT_BITS'(64'(n) << nsr_pkg::FRAC_BITS);
		end
		guess  = 64'(n >> 1) << nsr_pkg::FRAC_BITS;
		scaled = 128'(n) << (2 * nsr_pkg::FRAC_BITS);
		for (int k = 0; k < int'(steps); k++) begin
			if (guess == 64'd0)
				quot = '1;
			else
				quot = 64'(scaled / 128'(guess));
			guess = (quot >> 1) + (guess >> 1) + 64'(quot[0] & guess[0]);
		end
		return guess[nsr_pkg::OUT_BITS-1:0];
	endfunction

	function automatic logic [nsr_pkg::INPUT_BITS-1:0] random_radicand();
		int unsigned k;
		case ($urandom_range(9))
			0: return nsr_pkg::INPUT_BITS'($urandom_range(3));
			1: return nsr_pkg::INPUT_BITS'($urandom_range(255));
			2: begin
				k = $urandom_range(46340);
				return nsr_pkg::INPUT_BITS'(k * k);
			end
			3: return nsr_pkg::INPUT_BITS'(1) << $urandom_range(nsr_pkg::INPUT_BITS - 1);
			4: return {nsr_pkg::INPUT_BITS{1'b1}} - nsr_pkg::INPUT_BITS'($urandom_range(15));
			5: return nsr_pkg::INPUT_BITS'($urandom >> $urandom_range(31));
			default: return nsr_pkg::INPUT_BITS'($urandom);
		endcase
	endfunction

	// monitor, receiver stalls and watchdog
	always @(posedge clk) begin
		logic [nsr_pkg::OUT_BITS-1:0] want;
		logic                         took_in;
		logic                         took_out;
		if (arst_n) begin
			took_in  = in_valid && !in_stall;
			took_out = out_valid && !out_stall;
			if (took_out) begin
				if (expected_roots.size() == 0) begin
					$error("unexpected root_estimate %0d with nothing pending", root_estimate);
					mismatches++;
				end else begin
					want = expected_roots.pop_front();
					roots_checked++;
					if (root_estimate !== want) begin
						$error("root_estimate: expected %0d, actual %0d", want, root_estimate);
						mismatches++;
					end
				end
			end
			if (took_in || took_out)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("newton_square_root_tb: errors");
				$finish;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic drain();
		do @(posedge clk); while (expected_roots.size() != 0);
	endtask

	task automatic configure(input logic [nsr_pkg::ITER_BITS-1:0] steps);
		in_valid <= 1'b0;
		drain();
		repeat (2) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= steps;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= nsr_pkg::ITER_BITS'($urandom);
		iter_setting  = steps;
	endtask

	task automatic send_item(input logic [nsr_pkg::INPUT_BITS-1:0] value, input logic known,
		input logic [nsr_pkg::OUT_BITS-1:0] root);
		in_valid <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (in_stall);
		expected_roots.push_back(known ? root : newton_root(value, iter_setting));
		items_sent++;
	endtask

	// idle the sender now and then; occasionally hold until every root is back
	task automatic after_item(input int index);
		logic pressure;
		logic idle;
		pressure = (index == 40) || ($urandom_range(59) == 0);
		idle     = ($urandom_range(99) < send_idle_pct);
		if (pressure || idle) begin
			in_valid <= 1'b0;
			radicand <= nsr_pkg::INPUT_BITS'($urandom);
			if (pressure)
				drain();
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic run_segment(input logic [nsr_pkg::ITER_BITS-1:0] steps, input int count,
		input int send_pct, input int recv_pct);
		configure(steps);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			send_item(random_radicand(), 1'b0, '0);
			if (i < count - 1)
				after_item(i);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		radicand      = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		iter_setting  = nsr_pkg::ITER_RESET;
		send_idle_pct = 21;
		recv_idle_pct = 88;
		items_sent    = 0;
		dir_rows = '{
			'{6'd10, 31'd0,          1'b1, 47'd0},
			'{6'd10, 31'd1,          1'b1, 47'd65536},
			'{6'd10, 31'd2,          1'b0, 47'd0},
			'{6'd10, 31'd4,          1'b0, 47'd0},
			'{6'd10, 31'd16,         1'b0, 47'd0},
			'{6'd10, 31'd3,          1'b0, 47'd0},
			'{6'd10, 31'h40000000,   1'b0, 47'd0},
			'{6'd10, 31'h7FFFFFFF,   1'b0, 47'd0},
			'{6'd0,  31'd2,          1'b1, 47'd65536},
			'{6'd0,  31'h7FFFFFFF,   1'b1, 47'd70368744112128},
			'{6'd0,  31'd100,        1'b1, 47'd3276800},
			'{6'd0,  31'd0,          1'b1, 47'd0},
			'{6'd0,  31'd1,          1'b1, 47'd65536},
			'{6'd1,  31'd1,          1'b1, 47'd65536},
			'{6'd1,  31'd2,          1'b0, 47'd0},
			'{6'd1,  31'h7FFFFFFF,   1'b0, 47'd0},
			'{6'd1,  31'h2AAAAAAA,   1'b0, 47'd0},
			'{6'd1,  31'h55555555,   1'b0, 47'd0},
			'{6'd63, 31'h7FFFFFFF,   1'b0, 47'd0},
			'{6'd63, 31'd2,          1'b0, 47'd0},
			'{6'd63, 31'd1000000,    1'b0, 47'd0},
			'{6'd63, 31'd0,          1'b1, 47'd0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].steps != iter_setting)
				configure(dir_rows[r].steps);
			send_item(dir_rows[r].value, dir_rows[r].known, dir_rows[r].root);
			after_item(r + 1);
		end

		run_segment(6'd10, 150, 21, 88);
		run_segment(6'd1,  150, 21, 88);
		run_segment(6'd3,  150, 88, 21);
		run_segment(6'd63, 10,  88, 21);
		run_segment(6'd10, 150, 88, 21);
		run_segment(6'd1,  150, 0,  0);
		run_segment(6'd7,  200, 0,  0);
		run_segment(6'd2,  190, 0,  0);
		in_valid <= 1'b0;

		drain();
		repeat (300) @(posedge clk);
		$display("%0d radicands sent, %0d roots checked, iteration counts 0 to 63",
			items_sent, roots_checked);
		$display("sender and receiver stalls swapped between phases, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("newton_square_root_tb: clean");
		else
			$display("newton_square_root_tb: errors");
		$finish;
	end

endmodule
